@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the virial tensor accumulator.
// Assertions compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/vta_pkg.sv @@
// Package for the virial tensor accumulator: widths, codes, item type
// and helper functions. No dependencies.
`default_nettype none

package vta_pkg;

   // Data and accumulator widths
   localparam int DATA_WIDTH = 32;
   localparam int ACC_WIDTH  = 64;
   localparam int IN_W       = 32;
   localparam int TV_W       = 64;
   localparam int IDX_W      = 4;

   // Product and rounding widths: three Q16.16 factors give 48 fraction bits
   localparam int FRAC_DROP  = 16;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int FULL_W     = 3 * DATA_WIDTH;
   localparam int RND_W      = FULL_W - FRAC_DROP;
   localparam int CMP_W      = RND_W + ACC_WIDTH;

   // Tensor element codes
   localparam int                NUM_ELEM  = 9;
   localparam logic [IDX_W-1:0]  FIRST_IDX = IDX_W'(0);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_ELEM - 1);
   localparam logic [1:0]        AXIS_X    = 2'd0;
   localparam logic [1:0]        AXIS_Z    = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Saturation bounds
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [FULL_W-1:0]    ROUND_BIAS = FULL_W'(1) << (FRAC_DROP - 1);

   // One classified item as it travels from front to back
   typedef struct packed {
      logic                       add;
      logic                       last;
      logic                       p_neg;
      logic [DATA_WIDTH-1:0]      p_mag;
      logic [2:0]                 e_neg;
      logic [2:0][DATA_WIDTH-1:0] e_mag;
      logic [2:0]                 d_neg;
      logic [2:0][DATA_WIDTH-1:0] d_mag;
   } vta_item_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } vta_qstat_type;

   // Magnitude of the low DATA_WIDTH bits taken as a signed value
   function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [IN_W-1:0] v);
      logic [DATA_WIDTH-1:0] s;
      s = v[DATA_WIDTH-1:0];
      return s[DATA_WIDTH-1] ? (~s + 1'b1) : s;
   endfunction

   // Sign of the low DATA_WIDTH bits
   function automatic logic sign_of(input logic [IN_W-1:0] v);
      return v[DATA_WIDTH-1];
   endfunction

endpackage

`default_nettype wire

@@ rtl/virial_tensor_accumulator.sv @@
// Virial tensor accumulator: top level joining front end, queue and back end.
// Depends on vta_pkg, vta_front, vta_queue, vta_back and assert_macros.svh.
//
// Usage:
//   The req_ channel carries one neighbour/descriptor-component pair per item:
//   valid flag, network derivative p, environment derivative e and
//   displacement d, all Q16.16. Valid items add round(p*e[c]*d[r]) into
//   element c*3+r of a 3x3 Q32.32 tensor, saturating. An item with
//   req_frame_end makes the rsp_ channel deliver nine items, elements 0..8,
//   rsp_last_element on the ninth, after which the tensor is zero again.
//   The back end takes one item at a time. A valid item runs nine terms of
//   four steps each (low product, high product, round, accumulate), plus
//   one load step and three p*e products; all products use one shared
//   32x32 multiplier. An invalid item is popped with no products.
//   A four-entry queue keeps req_ready high while the back end works and
//   the queue is not full. Reset clears the tensor, the queue and the
//   output valid flag. When the receiver stalls, the result is held and
//   readout pauses; the queue keeps taking items until full.
`default_nettype none
`include "assert_macros.svh"

module virial_tensor_accumulator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_neighbor_valid,
   input  logic signed [31:0]            req_net_derivative,
   input  logic signed [31:0]            req_env_grad_x,
   input  logic signed [31:0]            req_env_grad_y,
   input  logic signed [31:0]            req_env_grad_z,
   input  logic signed [31:0]            req_disp_x,
   input  logic signed [31:0]            req_disp_y,
   input  logic signed [31:0]            req_disp_z,
   input  logic                          req_frame_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vta_pkg::IDX_W-1:0]     rsp_tensor_index,
   output logic signed [vta_pkg::TV_W-1:0] rsp_tensor_value,
   output logic                          rsp_last_element
);
   import vta_pkg::*;

   vta_qstat_type q_stat;
   vta_item_type  push_item;
   vta_item_type  head;
   logic          push;
   logic          pop;

   // Accept and classify
   vta_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_neighbor_valid (req_neighbor_valid),
      .req_net_derivative (req_net_derivative),
      .req_env_grad_x     (req_env_grad_x),
      .req_env_grad_y     (req_env_grad_y),
      .req_env_grad_z     (req_env_grad_z),
      .req_disp_x         (req_disp_x),
      .req_disp_y         (req_disp_y),
      .req_disp_z         (req_disp_z),
      .req_frame_end      (req_frame_end),
      .q_stat             (q_stat),
      .push               (push),
      .push_item          (push_item)
   );

   // Decouple front from back
   vta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // Accumulate and read out
   vta_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_stat           (q_stat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tensor_index (rsp_tensor_index),
      .rsp_tensor_value (rsp_tensor_value),
      .rsp_last_element (rsp_last_element)
   );

   // Checks
   `ASSERT_NEVER(a_push_full, clock, reset, push && q_stat.full, "push into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && q_stat.empty, "pop from empty queue")
   `ASSERT_PROP(a_last_idx, clock, reset, rsp_valid |-> (rsp_last_element == (rsp_tensor_index == LAST_IDX)), "last flag off the final element")
   `ASSERT_PROP(a_idx_step, clock, reset, (rsp_valid && rsp_ready && !rsp_last_element) |=> (!rsp_valid || (rsp_tensor_index == ($past(rsp_tensor_index) + 4'd1))), "element index skipped")

endmodule

`default_nettype wire

@@ rtl/vta_front.sv @@
// Front end: accepts request items and splits operands into sign and magnitude.
// Depends on vta_pkg.
`default_nettype none

module vta_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_neighbor_valid,
   input  logic signed [31:0]         req_net_derivative,
   input  logic signed [31:0]         req_env_grad_x,
   input  logic signed [31:0]         req_env_grad_y,
   input  logic signed [31:0]         req_env_grad_z,
   input  logic signed [31:0]         req_disp_x,
   input  logic signed [31:0]         req_disp_y,
   input  logic signed [31:0]         req_disp_z,
   input  logic                       req_frame_end,
   input  vta_pkg::vta_qstat_type     q_stat,
   output logic                       push,
   output vta_pkg::vta_item_type      push_item
);
   import vta_pkg::*;

   // Take an item whenever the queue has room
   assign req_ready = !q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // Classify and convert operands
   always_comb begin
      push_item.add      = req_neighbor_valid;
      push_item.last     = req_frame_end;
      push_item.p_neg    = sign_of(req_net_derivative);
      push_item.p_mag    = mag_of(req_net_derivative);
      push_item.e_neg[0] = sign_of(req_env_grad_x);
      push_item.e_neg[1] = sign_of(req_env_grad_y);
      push_item.e_neg[2] = sign_of(req_env_grad_z);
      push_item.e_mag[0] = mag_of(req_env_grad_x);
      push_item.e_mag[1] = mag_of(req_env_grad_y);
      push_item.e_mag[2] = mag_of(req_env_grad_z);
      push_item.d_neg[0] = sign_of(req_disp_x);
      push_item.d_neg[1] = sign_of(req_disp_y);
      push_item.d_neg[2] = sign_of(req_disp_z);
      push_item.d_mag[0] = mag_of(req_disp_x);
      push_item.d_mag[1] = mag_of(req_disp_y);
      push_item.d_mag[2] = mag_of(req_disp_z);
   end

endmodule

`default_nettype wire

@@ rtl/vta_queue.sv @@
// Short item queue between the front end and the back end.
// Depends on vta_pkg.
`default_nettype none

module vta_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  vta_pkg::vta_item_type   push_item,
   input  logic                    pop,
   output vta_pkg::vta_item_type   head,
   output vta_pkg::vta_qstat_type  q_stat
);
   import vta_pkg::*;

   vta_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // Status and head of queue
   assign q_stat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/vta_back.sv @@
// Back end: per-item multiply, round, saturate and accumulate sequencer,
// plus the tensor readout. Depends on vta_pkg.
`default_nettype none

module vta_back (
   input  logic                         clock,
   input  logic                         reset,
   input  vta_pkg::vta_item_type        head,
   input  vta_pkg::vta_qstat_type       q_stat,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [vta_pkg::IDX_W-1:0]    rsp_tensor_index,
   output logic signed [vta_pkg::TV_W-1:0] rsp_tensor_value,
   output logic                         rsp_last_element
);
   import vta_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PE, S_LO, S_HI, S_RND, S_ACC, S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   vta_item_type                 cur_ff, cur_in;
   logic [1:0]                   c_ff, c_in;
   logic [1:0]                   r_ff, r_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [PROD_W-1:0]            pe_ff, pe_in;
   logic [PROD_W-1:0]            t0_ff, t0_in;
   logic [PROD_W-1:0]            t1_ff, t1_in;
   logic signed [ACC_WIDTH-1:0]  term_ff, term_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff [NUM_ELEM];
   logic signed [ACC_WIDTH-1:0]  acc_in [NUM_ELEM];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]             rsp_index_ff, rsp_index_in;
   logic signed [TV_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [DATA_WIDTH-1:0]        mul_a, mul_b;
   logic [PROD_W-1:0]            mul;
   logic [FULL_W-1:0]            full_prod;
   logic [RND_W-1:0]             rnd;
   logic                         neg;
   logic                         over;
   logic signed [ACC_WIDTH-1:0]  acc_rd;
   logic signed [ACC_WIDTH:0]    sum;
   logic signed [ACC_WIDTH-1:0]  sum_sat;
   logic                         out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tensor_index = rsp_index_ff;
   assign rsp_tensor_value = rsp_value_ff;
   assign rsp_last_element = rsp_last_ff;

   // Shared multiplier: p*e, then low and high halves of (p*e)*d
   always_comb begin
      case (state_ff)
         S_PE: begin
            mul_a = cur_ff.p_mag;
            mul_b = cur_ff.e_mag[c_ff];
         end
         S_LO: begin
            mul_a = pe_ff[DATA_WIDTH-1:0];
            mul_b = cur_ff.d_mag[r_ff];
         end
         default: begin
            mul_a = pe_ff[PROD_W-1:DATA_WIDTH];
            mul_b = cur_ff.d_mag[r_ff];
         end
      endcase
      mul = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Round half away from zero on the magnitude, then saturate the term
   always_comb begin
      full_prod = (FULL_W'(t1_ff) << DATA_WIDTH) + FULL_W'(t0_ff) + ROUND_BIAS;
      rnd       = full_prod[FULL_W-1:FRAC_DROP];
      neg       = cur_ff.p_neg ^ cur_ff.e_neg[c_ff] ^ cur_ff.d_neg[r_ff];
      over      = CMP_W'(rnd) > (CMP_W'(ACC_MAX) + CMP_W'(neg));
      if (over) begin
         term_in = neg ? ACC_MIN : ACC_MAX;
      end else if (neg) begin
         term_in = -ACC_WIDTH'(rnd);
      end else begin
         term_in = ACC_WIDTH'(rnd);
      end
   end

   // Saturating add into the selected accumulator
   always_comb begin
      acc_rd = acc_ff[idx_ff];
      sum    = (ACC_WIDTH+1)'(acc_rd) + (ACC_WIDTH+1)'(term_ff);
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
         sum_sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = sum[ACC_WIDTH-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      idx_in       = idx_ff;
      pe_in        = pe_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cur_in = head;
               c_in   = AXIS_X;
               r_in   = AXIS_X;
               idx_in = FIRST_IDX;
               if (head.add) begin
                  state_in = S_PE;
               end else if (head.last) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_PE: begin
            pe_in    = mul;
            r_in     = AXIS_X;
            state_in = S_LO;
         end
         S_LO: begin
            t0_in    = mul;
            state_in = S_HI;
         end
         S_HI: begin
            t1_in    = mul;
            state_in = S_RND;
         end
         S_RND: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in[idx_ff] = sum_sat;
            idx_in         = idx_ff + 1'b1;
            if (r_ff == AXIS_Z) begin
               if (c_ff == AXIS_Z) begin
                  idx_in   = FIRST_IDX;
                  state_in = cur_ff.last ? S_EMIT : S_IDLE;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_PE;
               end
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = S_LO;
            end
         end
         S_EMIT: begin
            // Hand one element to the output register and clear it
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_index_in   = idx_ff;
               rsp_value_in   = TV_W'(acc_rd);
               rsp_last_in    = (idx_ff == LAST_IDX);
               acc_in[idx_ff] = '0;
               if (idx_ff == LAST_IDX) begin
                  idx_in   = FIRST_IDX;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ELEM; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      cur_ff       <= cur_in;
      c_ff         <= c_in;
      r_ff         <= r_in;
      idx_ff       <= idx_in;
      pe_ff        <= pe_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      term_ff      <= term_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire
